// ----- design/psalu_pkg.sv -----
`default_nettype none

package psalu_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned HalfW = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned NibW  = 4;

  localparam int unsigned NumHalf = WordW / HalfW;
  localparam int unsigned NumByte = WordW / ByteW;
  localparam int unsigned NumNib  = WordW / NibW;

  // Signed nibble products need 8 bits, signed or unsigned byte products 16 bits.
  localparam int unsigned NibProdW  = 2 * NibW;
  localparam int unsigned ByteProdW = 2 * ByteW;

  localparam int unsigned CmdW = 4;

  typedef enum logic [CmdW-1:0] {
    CmdAdd16  = 4'd0,
    CmdAdd8   = 4'd1,
    CmdSub16  = 4'd2,
    CmdSub8   = 4'd3,
    CmdWmul16 = 4'd4,
    CmdWmul16u = 4'd5,
    CmdWmul8  = 4'd6,
    CmdWmul8u = 4'd7,
    CmdDot16  = 4'd8,
    CmdDot8   = 4'd9,
    CmdDot4   = 4'd10
  } cmd_e;

  // Lane products and lanewise sums, registered after the multiply stage.
  typedef struct packed {
    logic [CmdW-1:0]                      cmd;
    logic [WordW-1:0]                     acc;
    logic [WordW-1:0]                     addsub;
    logic [NumHalf-1:0][WordW-1:0]        hprod;
    logic [NumByte-1:0][ByteProdW-1:0]    bprod;
    logic [NumNib-1:0][NibProdW-1:0]      nprod;
  } mul_stage_t;

  // Reduced products and packed words, registered before the final add.
  typedef struct packed {
    logic             is_dot;
    logic [WordW-1:0] acc;
    logic [WordW-1:0] psum;
    logic [WordW-1:0] word_lo;
    logic [WordW-1:0] word_hi;
  } sum_stage_t;

endpackage

`default_nettype wire

// ----- design/psalu_lane_mul.sv -----
`default_nettype none

module psalu_lane_mul (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  output logic                              ready_o,
  input  wire logic [psalu_pkg::CmdW-1:0]   cmd_i,
  input  wire logic [psalu_pkg::WordW-1:0]  op_a_i,
  input  wire logic [psalu_pkg::WordW-1:0]  op_b_i,
  input  wire logic [psalu_pkg::WordW-1:0]  acc_i,
  output logic                              valid_o,
  input  wire logic                         ready_i,
  output psalu_pkg::mul_stage_t             stage_o
);

  logic                  valid_q;
  psalu_pkg::mul_stage_t stage_d, stage_q;
  logic                  half_sgn, byte_sgn;

  assign half_sgn = (cmd_i == psalu_pkg::CmdWmul16) || (cmd_i == psalu_pkg::CmdDot16);
  assign byte_sgn = (cmd_i == psalu_pkg::CmdWmul8) || (cmd_i == psalu_pkg::CmdDot8);

  always_comb begin
    logic signed [psalu_pkg::HalfW:0]       ha, hb;
    logic signed [2*psalu_pkg::HalfW+1:0]   hp;
    logic signed [psalu_pkg::ByteW:0]       ba, bb;
    logic signed [2*psalu_pkg::ByteW+1:0]   bp;
    logic signed [psalu_pkg::NibW-1:0]      na, nb;
    logic signed [psalu_pkg::NibProdW-1:0]  np;
    logic [psalu_pkg::HalfW-1:0]            hs;
    logic [psalu_pkg::ByteW-1:0]            bs;
    stage_d     = '0;
    stage_d.cmd = cmd_i;
    stage_d.acc = acc_i;
    hs          = '0;
    bs          = '0;

    // Both signed and unsigned forms share one multiplier per lane; the
    // extra top bit carries the sign only for the signed operations.
    for (int i = 0; i < psalu_pkg::NumHalf; i++) begin
      ha = $signed({half_sgn & op_a_i[psalu_pkg::HalfW*i + psalu_pkg::HalfW-1],
                    op_a_i[psalu_pkg::HalfW*i +: psalu_pkg::HalfW]});
      hb = $signed({half_sgn & op_b_i[psalu_pkg::HalfW*i + psalu_pkg::HalfW-1],
                    op_b_i[psalu_pkg::HalfW*i +: psalu_pkg::HalfW]});
      hp = ha * hb;
      stage_d.hprod[i] = hp[psalu_pkg::WordW-1:0];
    end

    for (int i = 0; i < psalu_pkg::NumByte; i++) begin
      ba = $signed({byte_sgn & op_a_i[psalu_pkg::ByteW*i + psalu_pkg::ByteW-1],
                    op_a_i[psalu_pkg::ByteW*i +: psalu_pkg::ByteW]});
      bb = $signed({byte_sgn & op_b_i[psalu_pkg::ByteW*i + psalu_pkg::ByteW-1],
                    op_b_i[psalu_pkg::ByteW*i +: psalu_pkg::ByteW]});
      bp = ba * bb;
      stage_d.bprod[i] = bp[psalu_pkg::ByteProdW-1:0];
    end

    for (int i = 0; i < psalu_pkg::NumNib; i++) begin
      na = $signed(op_a_i[psalu_pkg::NibW*i +: psalu_pkg::NibW]);
      nb = $signed(op_b_i[psalu_pkg::NibW*i +: psalu_pkg::NibW]);
      np = psalu_pkg::NibProdW'(na) * psalu_pkg::NibProdW'(nb);
      stage_d.nprod[i] = np;
    end

    // Lanewise add and subtract; each lane wraps on its own.
    unique case (cmd_i)
      psalu_pkg::CmdAdd16, psalu_pkg::CmdSub16: begin
        for (int i = 0; i < psalu_pkg::NumHalf; i++) begin
          if (cmd_i == psalu_pkg::CmdSub16) begin
            hs = op_a_i[psalu_pkg::HalfW*i +: psalu_pkg::HalfW]
               - op_b_i[psalu_pkg::HalfW*i +: psalu_pkg::HalfW];
          end else begin
            hs = op_a_i[psalu_pkg::HalfW*i +: psalu_pkg::HalfW]
               + op_b_i[psalu_pkg::HalfW*i +: psalu_pkg::HalfW];
          end
          stage_d.addsub[psalu_pkg::HalfW*i +: psalu_pkg::HalfW] = hs;
        end
      end
      psalu_pkg::CmdAdd8, psalu_pkg::CmdSub8: begin
        for (int i = 0; i < psalu_pkg::NumByte; i++) begin
          if (cmd_i == psalu_pkg::CmdSub8) begin
            bs = op_a_i[psalu_pkg::ByteW*i +: psalu_pkg::ByteW]
               - op_b_i[psalu_pkg::ByteW*i +: psalu_pkg::ByteW];
          end else begin
            bs = op_a_i[psalu_pkg::ByteW*i +: psalu_pkg::ByteW]
               + op_b_i[psalu_pkg::ByteW*i +: psalu_pkg::ByteW];
          end
          stage_d.addsub[psalu_pkg::ByteW*i +: psalu_pkg::ByteW] = bs;
        end
      end
      default: begin
        stage_d.addsub = '0;
      end
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

`default_nettype wire

// ----- design/psalu_reduce.sv -----
`default_nettype none

module psalu_reduce (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  output logic                       ready_o,
  input  wire psalu_pkg::mul_stage_t stage_i,
  output logic                       valid_o,
  input  wire logic                  ready_i,
  output psalu_pkg::sum_stage_t      stage_o
);

  localparam int unsigned NibSumW  = psalu_pkg::NibProdW + 3;
  localparam int unsigned ByteSumW = psalu_pkg::ByteProdW + 2;

  logic                  valid_q;
  psalu_pkg::sum_stage_t stage_d, stage_q;
  logic [NibSumW-1:0]    nib_sum;
  logic [ByteSumW-1:0]   byte_sum;
  logic [psalu_pkg::WordW-1:0] half_sum;

  always_comb begin
    nib_sum = '0;
    for (int i = 0; i < psalu_pkg::NumNib; i++) begin
      nib_sum = nib_sum + {{(NibSumW-psalu_pkg::NibProdW){stage_i.nprod[i][psalu_pkg::NibProdW-1]}},
                           stage_i.nprod[i]};
    end
    byte_sum = '0;
    for (int i = 0; i < psalu_pkg::NumByte; i++) begin
      byte_sum = byte_sum
               + {{(ByteSumW-psalu_pkg::ByteProdW){stage_i.bprod[i][psalu_pkg::ByteProdW-1]}},
                  stage_i.bprod[i]};
    end
    half_sum = stage_i.hprod[0] + stage_i.hprod[1];
  end

  always_comb begin
    stage_d         = '0;
    stage_d.acc     = stage_i.acc;
    unique case (stage_i.cmd)
      psalu_pkg::CmdAdd16, psalu_pkg::CmdAdd8, psalu_pkg::CmdSub16, psalu_pkg::CmdSub8: begin
        stage_d.word_lo = stage_i.addsub;
      end
      psalu_pkg::CmdWmul16, psalu_pkg::CmdWmul16u: begin
        stage_d.word_lo = stage_i.hprod[0];
        stage_d.word_hi = stage_i.hprod[1];
      end
      psalu_pkg::CmdWmul8, psalu_pkg::CmdWmul8u: begin
        stage_d.word_lo = {stage_i.bprod[1], stage_i.bprod[0]};
        stage_d.word_hi = {stage_i.bprod[3], stage_i.bprod[2]};
      end
      psalu_pkg::CmdDot16: begin
        stage_d.is_dot = 1'b1;
        stage_d.psum   = half_sum;
      end
      psalu_pkg::CmdDot8: begin
        stage_d.is_dot = 1'b1;
        stage_d.psum   = {{(psalu_pkg::WordW-ByteSumW){byte_sum[ByteSumW-1]}}, byte_sum};
      end
      psalu_pkg::CmdDot4: begin
        stage_d.is_dot = 1'b1;
        stage_d.psum   = {{(psalu_pkg::WordW-NibSumW){nib_sum[NibSumW-1]}}, nib_sum};
      end
      default: begin
        // Unused codes give two zero words.
        stage_d.word_lo = '0;
      end
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

`default_nettype wire

// ----- design/packed_simd_alu_core.sv -----
// Channel  Direction  Ports                    Contents
// s_axis   in         tvalid/tready/tuser/tdata tuser: command; tdata: operand_a, operand_b,
//                                              accumulator
// m_axis   out        tvalid/tready/tdata       tdata: result_low, result_high
//
// Every request passes three register stages: lane multiplies and lanewise
// add/sub, then the product reduction, then the accumulator add into the output
// register. One request is accepted per cycle while s_axis_tready_o is high.
// Reset clears only the stage valid bits. A stall at the output backs up
// stage by stage; bubbles are squeezed out, so s_axis_tready_o drops only
// when all three stages hold data.
`default_nettype none

module packed_simd_alu_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [3:0]   s_axis_tuser_i,   // [3:0] command
  input  wire logic [95:0]  s_axis_tdata_i,   // [31:0] operand_a, [63:32] operand_b,
                                              // [95:64] accumulator
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic [63:0]       m_axis_tdata_o    // [31:0] result_low, [63:32] result_high
);

  logic                  mul_valid, mul_ready;
  psalu_pkg::mul_stage_t mul_stage;
  logic                  sum_valid, sum_ready;
  psalu_pkg::sum_stage_t sum_stage;

  logic                        out_valid_q;
  logic [psalu_pkg::WordW-1:0] lo_d, lo_q, hi_q;

  psalu_lane_mul u_lane_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .cmd_i   (s_axis_tuser_i),
    .op_a_i  (s_axis_tdata_i[31:0]),
    .op_b_i  (s_axis_tdata_i[63:32]),
    .acc_i   (s_axis_tdata_i[95:64]),
    .valid_o (mul_valid),
    .ready_i (mul_ready),
    .stage_o (mul_stage)
  );

  psalu_reduce u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mul_valid),
    .ready_o (mul_ready),
    .stage_i (mul_stage),
    .valid_o (sum_valid),
    .ready_i (sum_ready),
    .stage_o (sum_stage)
  );

  assign sum_ready = !out_valid_q || m_axis_tready_i;

  // Dot products add the accumulator here; everything else passes through.
  assign lo_d = sum_stage.is_dot ? (sum_stage.acc + sum_stage.psum) : sum_stage.word_lo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (sum_ready) begin
      out_valid_q <= sum_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_ready && sum_valid) begin
      lo_q <= lo_d;
      hi_q <= sum_stage.word_hi;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {hi_q, lo_q};

`ifndef SYNTHESIS
  // With the output free to drain, no stage may hold back the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready_i |-> s_axis_tready_o)
    else $error("input stalled while output is ready");

  // Dot products have no second result word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sum_valid && sum_stage.is_dot) |-> (sum_stage.word_hi == '0))
    else $error("dot product carries a nonzero high word");

  // A request moving out of the multiply stage shows up in the reduce stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mul_valid && mul_ready) |=> sum_valid)
    else $error("request lost between multiply and reduce stages");

  // A request moving out of the reduce stage shows up at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sum_valid && sum_ready) |=> m_axis_tvalid_o)
    else $error("request lost between reduce and output stages");
`endif

endmodule

`default_nettype wire
